### design/assert_macros.svh
// assertion macros shared by the echo reply builder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/iceb_pkg.sv
// types and constants of the icmp echo reply builder
`timescale 1ns / 1ps

package iceb_pkg;

    typedef enum logic [2:0] {
        CLASS_NOT_IP    = 3'd0,
        CLASS_TCP       = 3'd1,
        CLASS_UDP       = 3'd2,
        CLASS_ICMP      = 3'd3,
        CLASS_OTHER_IP  = 3'd4,
        CLASS_TRUNCATED = 3'd5
    } frame_class_t;

    localparam logic REG_TTL    = 1'b0;
    localparam logic REG_ENABLE = 1'b1;

    localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP        = 8'd1;
    localparam logic [7:0]  PROTO_TCP         = 8'd6;
    localparam logic [7:0]  PROTO_UDP         = 8'd17;
    localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;
    localparam logic [3:0]  MIN_HEADER_WORDS  = 4'd5;
    localparam logic [15:0] REPLY_LENGTH      = 16'd28;
    localparam logic [7:0]  TTL_RESET         = 8'd20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        frame_class_t frame_class;
        logic         reply_valid;
        logic [31:0]  source_ip;
        logic [31:0]  dest_ip;
        logic [15:0]  ident;
        logic [15:0]  sequence_num;
    } frame_rec_t;

    typedef struct packed {
        logic       empty;
        logic       full;
    } queue_status_t;

endpackage

### design/icmp_echo_reply_builder.sv
// top level of the icmp echo reply builder
`timescale 1ns / 1ps
// Usage:
// Frame bytes enter on data_byte with last_byte marking the final byte of a
// frame. A beat is taken when push is high and full is low; one byte per
// cycle is sustained while the result queue has room.
// Every frame yields exactly one result on the output queue: frame_class,
// and for an icmp echo request (with reply_enable set) the reply fields.
// Reply fields read zero when reply_valid is low.
// A result is on the outputs while empty is low and is taken by pop. The
// first result passes the queue write, the queue read and the result
// register after its last byte is taken. One result per cycle can drain
// while pop is high. A stalled receiver fills a four-entry record queue;
// full then rises and holds off input beats until results are popped.
// Registers reply_ttl (index 0) and reply_enable (index 1) are written by
// cfg_write_en, cfg_index and cfg_data; the user writes them only while no
// frame is in flight; the block does not enforce it. Reset clears the parser
// and queue, empties the result register, sets reply_ttl 20, reply_enable 1.

module icmp_echo_reply_builder import iceb_pkg::*; #(
    parameter int MAC_HEADER_BYTES = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  frame_class,
    output logic        reply_valid,
    output logic [31:0] reply_source_ip,
    output logic [31:0] reply_dest_ip,
    output logic [15:0] echo_ident,
    output logic [15:0] echo_sequence,
    output logic [15:0] reply_checksum,
    output logic [7:0]  reply_time_to_live,
    output logic [15:0] reply_total_length,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0]    ttl_reg;
    logic          enable_reg;
    logic          beat_in;
    logic          rec_write;
    frame_rec_t    rec;
    frame_rec_t    q_data;
    logic          q_rd;
    queue_status_t q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg    <= TTL_RESET;
            enable_reg <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_TTL:    ttl_reg    <= cfg_data;
                REG_ENABLE: enable_reg <= cfg_data[0];
            endcase
        end
    end

    assign full    = q_status.full;
    assign beat_in = push && !q_status.full;

    iceb_front #(
        .MAC_HEADER_BYTES (MAC_HEADER_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat_in      (beat_in),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .reply_enable (enable_reg),
        .rec_write    (rec_write),
        .rec          (rec)
    );

    iceb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_write),
        .wr_data (rec),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .status  (q_status)
    );

    iceb_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_status           (q_status),
        .q_data             (q_data),
        .q_rd               (q_rd),
        .reply_ttl          (ttl_reg),
        .pop                (pop),
        .empty              (empty),
        .frame_class        (frame_class),
        .reply_valid        (reply_valid),
        .reply_source_ip    (reply_source_ip),
        .reply_dest_ip      (reply_dest_ip),
        .echo_ident         (echo_ident),
        .echo_sequence      (echo_sequence),
        .reply_checksum     (reply_checksum),
        .reply_time_to_live (reply_time_to_live),
        .reply_total_length (reply_total_length)
    );

endmodule

### design/iceb_front.sv
// frame parser: byte offset tracking, field capture and classification
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iceb_front import iceb_pkg::*; #(
    parameter int MAC_HEADER_BYTES = 14
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       beat_in,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       reply_enable,
    output logic       rec_write,
    output frame_rec_t rec
);

    localparam int OFF_W = $clog2(MAC_HEADER_BYTES + 69);
    localparam logic [OFF_W-1:0] M         = OFF_W'(MAC_HEADER_BYTES);
    localparam logic [OFF_W-1:0] OFF_MAX   = '1;

    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [15:0]      ether_reg, ether_next;
    logic [3:0]       hw_reg, hw_next;
    logic [7:0]       proto_reg, proto_next;
    logic [31:0]      src_reg, src_next;
    logic [31:0]      dst_reg, dst_next;
    logic [7:0]       type_reg, type_next;
    logic [15:0]      id_reg, id_next;
    logic [15:0]      seq_reg, seq_next;

    logic [3:0]       hw_eff;
    logic [OFF_W-1:0] ic;
    logic [OFF_W-1:0] pos;
    frame_class_t     cls;
    logic             valid;

    assign pos = offset_reg;

    // capture of this beat's byte
    always_comb
    begin
        ether_next = ether_reg;
        hw_next    = hw_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        type_next  = type_reg;
        id_next    = id_reg;
        seq_next   = seq_reg;
        if (pos == M - OFF_W'(2) || pos == M - OFF_W'(1))
        begin
            ether_next = {ether_reg[7:0], data_byte};
        end
        if (pos == M)
        begin
            hw_next = data_byte[3:0];
        end
        if (pos == M + OFF_W'(9))
        begin
            proto_next = data_byte;
        end
        if (pos >= M + OFF_W'(12) && pos < M + OFF_W'(16))
        begin
            src_next = {src_reg[23:0], data_byte};
        end
        if (pos >= M + OFF_W'(16) && pos < M + OFF_W'(20))
        begin
            dst_next = {dst_reg[23:0], data_byte};
        end
        hw_eff = (hw_next < MIN_HEADER_WORDS) ? MIN_HEADER_WORDS : hw_next;
        ic     = M + OFF_W'({hw_eff, 2'b00});
        if (pos == ic)
        begin
            type_next = data_byte;
        end
        if (pos == ic + OFF_W'(4) || pos == ic + OFF_W'(5))
        begin
            id_next = {id_reg[7:0], data_byte};
        end
        if (pos == ic + OFF_W'(6) || pos == ic + OFF_W'(7))
        begin
            seq_next = {seq_reg[7:0], data_byte};
        end
    end

    // classification on the last beat, length = pos + 1
    always_comb
    begin
        valid = 1'b0;
        if (pos < M - OFF_W'(1))
        begin
            cls = CLASS_TRUNCATED;
        end
        else if (ether_next != ETHERTYPE_IPV4)
        begin
            cls = CLASS_NOT_IP;
        end
        else if (pos < M + OFF_W'(19))
        begin
            cls = CLASS_TRUNCATED;
        end
        else if (proto_next == PROTO_TCP)
        begin
            cls = CLASS_TCP;
        end
        else if (proto_next == PROTO_UDP)
        begin
            cls = CLASS_UDP;
        end
        else if (proto_next == PROTO_ICMP)
        begin
            if (pos < ic + OFF_W'(7))
            begin
                cls = CLASS_TRUNCATED;
            end
            else
            begin
                cls   = CLASS_ICMP;
                valid = (type_next == ICMP_ECHO_REQUEST) && reply_enable;
            end
        end
        else
        begin
            cls = CLASS_OTHER_IP;
        end
    end

    assign rec_write        = beat_in && last_byte;
    assign rec.frame_class  = cls;
    assign rec.reply_valid  = valid;
    assign rec.source_ip    = src_next;
    assign rec.dest_ip      = dst_next;
    assign rec.ident        = id_next;
    assign rec.sequence_num = seq_next;

    assign offset_next = (offset_reg != OFF_MAX) ? offset_reg + OFF_W'(1) : offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            ether_reg  <= '0;
            hw_reg     <= '0;
            proto_reg  <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
            type_reg   <= '0;
            id_reg     <= '0;
            seq_reg    <= '0;
        end
        else if (beat_in)
        begin
            if (last_byte)
            begin
                offset_reg <= '0;
                ether_reg  <= '0;
                hw_reg     <= '0;
                proto_reg  <= '0;
                src_reg    <= '0;
                dst_reg    <= '0;
                type_reg   <= '0;
                id_reg     <= '0;
                seq_reg    <= '0;
            end
            else
            begin
                offset_reg <= offset_next;
                ether_reg  <= ether_next;
                hw_reg     <= hw_next;
                proto_reg  <= proto_next;
                src_reg    <= src_next;
                dst_reg    <= dst_next;
                type_reg   <= type_next;
                id_reg     <= id_next;
                seq_reg    <= seq_next;
            end
        end
    end

    `ASSERT_NEXT(a_frame_end_clears, clk, rst_n, beat_in && last_byte, offset_reg == '0 && ether_reg == '0)

endmodule

### design/iceb_queue.sv
// short record queue between parser and reply stage
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iceb_queue import iceb_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  frame_rec_t    wr_data,
    input  logic          rd_en,
    output frame_rec_t    rd_data,
    output queue_status_t status
);

    localparam int CNT_W = QUEUE_AW + 1;

    frame_rec_t          mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    frame_rec_t          rd_data_reg;

    assign status.empty    = (count_reg == '0);
    assign status.full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_data         = rd_data_reg;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    `ASSERT_AT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH))
    `ASSERT_AT(a_no_overflow, clk, rst_n, !(wr_en && status.full))
    `ASSERT_AT(a_no_underflow, clk, rst_n, !(rd_en && status.empty))

endmodule

### design/iceb_back.sv
// reply stage: queue read, checksum and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iceb_back import iceb_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  frame_rec_t    q_data,
    output logic          q_rd,
    input  logic [7:0]    reply_ttl,
    input  logic          pop,
    output logic          empty,
    output logic [2:0]    frame_class,
    output logic          reply_valid,
    output logic [31:0]   reply_source_ip,
    output logic [31:0]   reply_dest_ip,
    output logic [15:0]   echo_ident,
    output logic [15:0]   echo_sequence,
    output logic [15:0]   reply_checksum,
    output logic [7:0]    reply_time_to_live,
    output logic [15:0]   reply_total_length
);

    logic        pend_reg, pend_next;
    logic        out_valid_reg;
    logic        consume;
    logic [16:0] raw_sum;
    logic [15:0] folded;

    logic [2:0]  class_reg;
    logic        rvalid_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [15:0] id_reg;
    logic [15:0] seq_reg;
    logic [15:0] csum_reg;
    logic [7:0]  ttl_reg;
    logic [15:0] len_reg;

    assign consume = pend_reg && (!out_valid_reg || pop);
    assign q_rd    = !q_status.empty && (!pend_reg || consume);

    always_comb
    begin
        pend_next = pend_reg;
        if (q_rd)
        begin
            pend_next = 1'b1;
        end
        else if (consume)
        begin
            pend_next = 1'b0;
        end
    end

    // end-around carry of id + seq, a second fold cannot carry
    assign raw_sum = {1'b0, q_data.ident} + {1'b0, q_data.sequence_num};
    assign folded  = raw_sum[15:0] + {15'd0, raw_sum[16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (consume)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            class_reg  <= q_data.frame_class;
            rvalid_reg <= q_data.reply_valid;
            if (q_data.reply_valid)
            begin
                src_reg  <= q_data.dest_ip;
                dst_reg  <= q_data.source_ip;
                id_reg   <= q_data.ident;
                seq_reg  <= q_data.sequence_num;
                csum_reg <= ~folded;
                ttl_reg  <= reply_ttl;
                len_reg  <= REPLY_LENGTH;
            end
            else
            begin
                src_reg  <= '0;
                dst_reg  <= '0;
                id_reg   <= '0;
                seq_reg  <= '0;
                csum_reg <= '0;
                ttl_reg  <= '0;
                len_reg  <= '0;
            end
        end
    end

    assign empty              = !out_valid_reg;
    assign frame_class        = class_reg;
    assign reply_valid        = rvalid_reg;
    assign reply_source_ip    = src_reg;
    assign reply_dest_ip      = dst_reg;
    assign echo_ident         = id_reg;
    assign echo_sequence      = seq_reg;
    assign reply_checksum     = csum_reg;
    assign reply_time_to_live = ttl_reg;
    assign reply_total_length = len_reg;

    `ASSERT_NEXT(a_pending_held, clk, rst_n, pend_reg && !consume, pend_reg && $stable(q_data))
    `ASSERT_NEXT(a_stalled_result_held, clk, rst_n, out_valid_reg && !pop, out_valid_reg && $stable(class_reg))

endmodule

### verif/echo_reply_checker.sv
// checker for the icmp echo reply builder: predicts one result per frame and compares
`timescale 1ns / 1ps

module echo_reply_checker import iceb_pkg::*; #(
    parameter int MAC_HEADER_BYTES = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  frame_class,
    input  logic        reply_valid,
    input  logic [31:0] reply_source_ip,
    input  logic [31:0] reply_dest_ip,
    input  logic [15:0] echo_ident,
    input  logic [15:0] echo_sequence,
    input  logic [15:0] reply_checksum,
    input  logic [7:0]  reply_time_to_live,
    input  logic [15:0] reply_total_length,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          outstanding
);

    localparam int M = MAC_HEADER_BYTES;
    localparam logic [10:0] POS_CAP = 11'h7ff;

    typedef struct {
        frame_class_t cls;
        logic         valid;
        logic [31:0]  src_ip;
        logic [31:0]  dst_ip;
        logic [15:0]  ident;
        logic [15:0]  seq;
        logic [15:0]  csum;
        logic [7:0]   ttl;
        logic [15:0]  total_len;
    } echo_result_t;

    echo_result_t replies_due[$];

    // per-frame parse state
    logic [10:0] pos;
    logic [15:0] eth_type;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [7:0]  msg_type;
    logic [15:0] msg_id;
    logic [15:0] msg_seq;

    logic [7:0]  ttl_cfg;
    logic        reply_en;

    function automatic int unsigned icmp_base();
        int unsigned words;
        words = (ihl < MIN_HEADER_WORDS) ? 32'(MIN_HEADER_WORDS) : 32'(ihl);
        return M + 4 * words;
    endfunction

    function automatic logic [15:0] echo_csum(input logic [15:0] id, input logic [15:0] sq);
        logic [16:0] s;
        s = {1'b0, id} + {1'b0, sq};
        s = {1'b0, s[15:0]} + s[16];
        s = {1'b0, s[15:0]} + s[16];
        return ~s[15:0];
    endfunction

    task automatic clear_frame();
        pos = '0;
        eth_type = '0;
        ihl = '0;
        proto = '0;
        ip_src = '0;
        ip_dst = '0;
        msg_type = '0;
        msg_id = '0;
        msg_seq = '0;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic is_last);
        int unsigned p;
        int unsigned ic;
        int unsigned frame_len;
        echo_result_t r;
        p = 32'(pos);
        if (p == M - 2 || p == M - 1)
            eth_type = {eth_type[7:0], b};
        if (p == M)
            ihl = b[3:0];
        if (p == M + 9)
            proto = b;
        if (p >= M + 12 && p < M + 16)
            ip_src = {ip_src[23:0], b};
        if (p >= M + 16 && p < M + 20)
            ip_dst = {ip_dst[23:0], b};
        ic = icmp_base();
        if (p == ic)
            msg_type = b;
        if (p == ic + 4 || p == ic + 5)
            msg_id = {msg_id[7:0], b};
        if (p == ic + 6 || p == ic + 7)
            msg_seq = {msg_seq[7:0], b};

        if (!is_last) begin
            if (pos != POS_CAP)
                pos = pos + 1'b1;
        end
        else begin
            frame_len = p + 1;
            r.cls = CLASS_OTHER_IP;
            r.valid = 1'b0;
            r.src_ip = '0;
            r.dst_ip = '0;
            r.ident = '0;
            r.seq = '0;
            r.csum = '0;
            r.ttl = '0;
            r.total_len = '0;
            if (frame_len < M)
                r.cls = CLASS_TRUNCATED;
            else if (eth_type != ETHERTYPE_IPV4)
                r.cls = CLASS_NOT_IP;
            else if (frame_len < M + 20)
                r.cls = CLASS_TRUNCATED;
            else if (proto == PROTO_TCP)
                r.cls = CLASS_TCP;
            else if (proto == PROTO_UDP)
                r.cls = CLASS_UDP;
            else if (proto == PROTO_ICMP) begin
                if (frame_len < icmp_base() + 8)
                    r.cls = CLASS_TRUNCATED;
                else begin
                    r.cls = CLASS_ICMP;
                    r.valid = (msg_type == ICMP_ECHO_REQUEST) && reply_en;
                end
            end
            if (r.valid) begin
                r.src_ip = ip_dst;
                r.dst_ip = ip_src;
                r.ident = msg_id;
                r.seq = msg_seq;
                r.csum = echo_csum(msg_id, msg_seq);
                r.ttl = ttl_cfg;
                r.total_len = REPLY_LENGTH;
            end
            replies_due.push_back(r);
            clear_frame();
        end
    endtask

    task automatic check_result();
        echo_result_t want;
        logic bad;
        if (replies_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result beat with nothing expected, class=%0d valid=%0b",
                         $realtime, frame_class, reply_valid);
        end
        else begin
            want = replies_due.pop_front();
            bad = (frame_class !== want.cls) || (reply_valid !== want.valid)
                || (reply_source_ip !== want.src_ip) || (reply_dest_ip !== want.dst_ip)
                || (echo_ident !== want.ident) || (echo_sequence !== want.seq)
                || (reply_checksum !== want.csum) || (reply_time_to_live !== want.ttl)
                || (reply_total_length !== want.total_len);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected class=%0d valid=%0b src=%h dst=%h id=%h seq=%h",
                             want.cls, want.valid, want.src_ip, want.dst_ip, want.ident,
                             want.seq);
                    $display("           csum=%h ttl=%0d len=%0d",
                             want.csum, want.ttl, want.total_len);
                    $display("  actual   class=%0d valid=%0b src=%h dst=%h id=%h seq=%h",
                             frame_class, reply_valid, reply_source_ip, reply_dest_ip,
                             echo_ident, echo_sequence);
                    $display("           csum=%h ttl=%0d len=%0d",
                             reply_checksum, reply_time_to_live, reply_total_length);
                end
            end
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            clear_frame();
            ttl_cfg = TTL_RESET;
            reply_en = 1'b1;
            replies_due.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_write_en) begin
                case (cfg_index)
                    REG_TTL:    ttl_cfg = cfg_data;
                    REG_ENABLE: reply_en = cfg_data[0];
                    default:    ;
                endcase
            end
            if (pop && !empty)
                check_result();
            if (push && !full)
                take_byte(data_byte, last_byte);
            outstanding <= replies_due.size();
        end
    end

endmodule

### verif/tb.sv
// testbench top for the icmp echo reply builder: frame stimulus, idling and verdict
`timescale 1ns / 1ps

module tb import iceb_pkg::*; ();

    localparam int MAC = 14;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  frame_class;
    logic        reply_valid;
    logic [31:0] reply_source_ip;
    logic [31:0] reply_dest_ip;
    logic [15:0] echo_ident;
    logic [15:0] echo_sequence;
    logic [15:0] reply_checksum;
    logic [7:0]  reply_time_to_live;
    logic [15:0] reply_total_length;
    logic        cfg_write_en = 1'b0;
    logic        cfg_index = REG_TTL;
    logic [7:0]  cfg_data = 8'h00;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int bytes_sent = 0;
    int frames_sent = 0;

    logic [7:0] frame_buf[$];

    icmp_echo_reply_builder #(.MAC_HEADER_BYTES(MAC)) u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_byte(data_byte), .last_byte(last_byte), .empty(empty), .pop(pop),
        .frame_class(frame_class), .reply_valid(reply_valid),
        .reply_source_ip(reply_source_ip), .reply_dest_ip(reply_dest_ip),
        .echo_ident(echo_ident), .echo_sequence(echo_sequence),
        .reply_checksum(reply_checksum), .reply_time_to_live(reply_time_to_live),
        .reply_total_length(reply_total_length), .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    echo_reply_checker #(.MAC_HEADER_BYTES(MAC)) u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_byte(data_byte), .last_byte(last_byte), .empty(empty), .pop(pop),
        .frame_class(frame_class), .reply_valid(reply_valid),
        .reply_source_ip(reply_source_ip), .reply_dest_ip(reply_dest_ip),
        .echo_ident(echo_ident), .echo_sequence(echo_sequence),
        .reply_checksum(reply_checksum), .reply_time_to_live(reply_time_to_live),
        .reply_total_length(reply_total_length), .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // frame of random bytes with header fields laid over it
    task automatic make_frame(input logic [15:0] etype, input logic [3:0] ihl_nib,
                              input logic [7:0] proto, input logic [7:0] msg_type,
                              input logic [15:0] id, input logic [15:0] sq,
                              input int pay, input int cut);
        int words;
        int base;
        int n;
        words = (ihl_nib < MIN_HEADER_WORDS) ? int'(MIN_HEADER_WORDS) : int'(ihl_nib);
        base = MAC + 4 * words;
        n = base + 8 + pay;
        frame_buf.delete();
        repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf[MAC - 2] = etype[15:8];
        frame_buf[MAC - 1] = etype[7:0];
        frame_buf[MAC] = (frame_buf[MAC] & 8'hf0) | {4'h0, ihl_nib};
        frame_buf[MAC + 9] = proto;
        frame_buf[base] = msg_type;
        frame_buf[base + 4] = id[15:8];
        frame_buf[base + 5] = id[7:0];
        frame_buf[base + 6] = sq[15:8];
        frame_buf[base + 7] = sq[7:0];
        if (cut > 0)
            while (frame_buf.size() > cut)
                void'(frame_buf.pop_back());
    endtask

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < send_idle) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        bytes_sent += frame_buf.size();
        frames_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] ttl, input logic en);
        wait_drained();
        cfg_write_en <= 1'b1;
        cfg_index <= REG_TTL;
        cfg_data <= ttl;
        @(posedge clk);
        cfg_index <= REG_ENABLE;
        cfg_data <= {7'd0, en};
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic directed_frames();
        frame_buf.delete();
        frame_buf.push_back(8'hff);
        send_frame();
        // short of the ethertype, short of the ip header, then non-ip and non-icmp frames
        make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_ICMP, ICMP_ECHO_REQUEST, 16'h1, 16'h1, 0, 13);
        send_frame();
        make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_ICMP, ICMP_ECHO_REQUEST, 16'h1, 16'h1, 0, 14);
        send_frame();
        make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 8'h00, 16'h1, 16'h1, 0, MAC + 19);
        send_frame();
        make_frame(16'h0801, 4'd5, PROTO_ICMP, ICMP_ECHO_REQUEST, 16'h1, 16'h1, 0, 14);
        send_frame();
        make_frame(16'h86dd, 4'd5, PROTO_ICMP, ICMP_ECHO_REQUEST, 16'h1, 16'h1, 10, 0);
        send_frame();
        make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 8'h08, 16'h0, 16'h0, 0, MAC + 20);
        send_frame();
        make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 8'h08, 16'h0, 16'h0, 12, 0);
        send_frame();
        make_frame(ETHERTYPE_IPV4, 4'd5, 8'd0, 8'h08, 16'h0, 16'h0, 3, 0);
        send_frame();
        make_frame(ETHERTYPE_IPV4, 4'd5, 8'd255, 8'h08, 16'h0, 16'h0, 3, 0);
        send_frame();
        // echo requests at the field extremes, then an echo reply
        make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_ICMP, ICMP_ECHO_REQUEST, 16'h0, 16'h0, 0, 0);
        for (int i = MAC + 12; i < MAC + 20; i++)
            frame_buf[i] = 8'h00;
        send_frame();
        make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_ICMP, ICMP_ECHO_REQUEST,
                   16'hffff, 16'hffff, 4, 0);
        for (int i = MAC + 12; i < MAC + 20; i++)
            frame_buf[i] = 8'hff;
        send_frame();
        make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_ICMP, 8'h00, 16'h1234, 16'h5678, 4, 0);
        send_frame();
        // icmp header one byte short, then just complete
        make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_ICMP, ICMP_ECHO_REQUEST,
                   16'hbeef, 16'h0001, 0, MAC + 27);
        send_frame();
        make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_ICMP, ICMP_ECHO_REQUEST,
                   16'hbeef, 16'h0002, 0, MAC + 28);
        send_frame();
        // header length below minimum and at maximum
        make_frame(ETHERTYPE_IPV4, 4'd0, PROTO_ICMP, ICMP_ECHO_REQUEST,
                   16'h8000, 16'h7fff, 2, 0);
        send_frame();
        make_frame(ETHERTYPE_IPV4, 4'd15, PROTO_ICMP, ICMP_ECHO_REQUEST,
                   16'h00ff, 16'hff00, 2, 0);
        send_frame();
        // long frame past the offset cap
        make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_ICMP, ICMP_ECHO_REQUEST,
                   16'h1234, 16'hfedc, 200 - (MAC + 28), 0);
        send_frame();

        set_config(8'd0, 1'b0);
        make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_ICMP, ICMP_ECHO_REQUEST,
                   16'h4321, 16'h8765, 6, 0);
        send_frame();
        set_config(8'd255, 1'b1);
        make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_ICMP, ICMP_ECHO_REQUEST,
                   16'h4321, 16'h8765, 6, 0);
        send_frame();
    endtask

    task automatic random_frame();
        int kind;
        int pay;
        int cut;
        logic [3:0] ihl_nib;
        logic [7:0] proto;
        logic [7:0] ty;
        kind = $urandom_range(0, 99);
        ihl_nib = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : MIN_HEADER_WORDS;
        pay = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        if (kind < 55) begin
            ty = ($urandom_range(0, 3) != 0) ? ICMP_ECHO_REQUEST : 8'($urandom_range(0, 255));
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 50) : 0;
            make_frame(ETHERTYPE_IPV4, ihl_nib, PROTO_ICMP, ty, 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), pay, cut);
        end
        else if (kind < 72) begin
            case ($urandom_range(0, 2))
                0:       proto = PROTO_TCP;
                1:       proto = PROTO_UDP;
                default: proto = 8'($urandom_range(0, 255));
            endcase
            make_frame(ETHERTYPE_IPV4, ihl_nib, proto, 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), pay, 0);
        end
        else if (kind < 80) begin
            make_frame(16'($urandom_range(0, 65535)), ihl_nib, PROTO_ICMP, ICMP_ECHO_REQUEST,
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), pay, 0);
        end
        else if (kind < 90) begin
            proto = ($urandom_range(0, 1) == 0) ? PROTO_ICMP : 8'($urandom_range(0, 255));
            make_frame(ETHERTYPE_IPV4, MIN_HEADER_WORDS, proto, ICMP_ECHO_REQUEST,
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 0,
                       $urandom_range(1, MAC + 27));
        end
        else begin
            frame_buf.delete();
            repeat ($urandom_range(1, 80)) frame_buf.push_back(8'($urandom_range(0, 255)));
        end
        send_frame();
    endtask

    task automatic random_phase(input int min_bytes, input int min_frames);
        int b0;
        int f0;
        b0 = bytes_sent;
        f0 = frames_sent;
        while (bytes_sent - b0 < min_bytes || frames_sent - f0 < min_frames)
            random_frame();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_frames();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       begin send_idle = 38; recv_idle <= 70; end
                1:       begin send_idle = 70; recv_idle <= 38; end
                default: begin send_idle = 0;  recv_idle <= 0;  end
            endcase
            for (int half = 0; half < 2; half++) begin
                case ($urandom_range(0, 2))
                    0:       set_config(8'd0, $urandom_range(0, 4) != 0);
                    1:       set_config(8'd255, $urandom_range(0, 4) != 0);
                    default: set_config(8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0);
                endcase
                random_phase(140, 4);
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/iceb_pkg.sv
design/iceb_front.sv
design/iceb_queue.sv
design/iceb_back.sv
design/icmp_echo_reply_builder.sv
verif/echo_reply_checker.sv
verif/tb.sv
